// ===== sv/jpic_pkg.sv =====
// jpic_pkg: shared types and constants of the joint pid / impedance controller
// register map, mode codes, multiplier operand codes, controller-to-datapath command
// no dependencies
package jpic_pkg;

    // configuration bus
    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    // register indexes (byte address is 4 * index)
    localparam logic [2:0] REG_MODE            = 3'd0;
    localparam logic [2:0] REG_GAIN_P          = 3'd1;
    localparam logic [2:0] REG_GAIN_I_DT       = 3'd2;
    localparam logic [2:0] REG_GAIN_D_OVER_DT  = 3'd3;
    localparam logic [2:0] REG_FILTER_ALPHA    = 3'd4;
    localparam logic [2:0] REG_TORQUE_LIMIT    = 3'd5;
    localparam logic [2:0] REG_GAIN_FF_GRAVITY = 3'd6;
    localparam logic [2:0] REG_GAIN_FF_DAMPING = 3'd7;

    // control modes
    localparam logic [1:0] MODE_OFF = 2'd0;
    localparam logic [1:0] MODE_PID = 2'd1;
    localparam logic [1:0] MODE_IMP = 2'd2;

    // reset values
    localparam logic [16:0] ALPHA_ONE       = 17'd65536;
    localparam logic [14:0] TORQUE_LIM_RST  = 15'd32767;

    // fixed point constants
    localparam int unsigned   TWO_PI_Q11  = 12868;
    localparam longint unsigned HALF_PI_Q28 = 64'd421657428;
    localparam longint unsigned ONE_Q28     = 64'd268435456;

    // datapath widths
    localparam int MUL_AW = 33;
    localparam int MUL_BW = 18;
    localparam int MUL_PW = MUL_AW + MUL_BW;
    localparam int ACC_W  = 56;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] gain_p;
        logic [15:0] gain_i_dt;
        logic [15:0] gain_d_over_dt;
        logic [16:0] filter_alpha;
        logic [14:0] torque_limit;
        logic [15:0] gain_ff_gravity;
        logic [15:0] gain_ff_damping;
    } t_cfg;

    // operand pairs of the shared multiplier
    typedef enum logic [3:0] {
        OP_POS_KEEP,
        OP_POS_NEW,
        OP_VEL_KEEP,
        OP_VEL_NEW,
        OP_P_ERR,
        OP_I_SUM,
        OP_D_DIFF,
        OP_D_VEL,
        OP_FF_REF,
        OP_FF_RATE,
        OP_G_SINE
    } t_opsel;

    typedef struct packed {
        logic   capture;
        t_opsel opsel;
        logic   acc_load;
        logic   acc_add;
        logic   shift3;
        logic   pos_wr;
        logic   d_zero;
        logic   vel_wr;
        logic   sum_wr;
        logic   out_wr;
        logic   out_zero;
    } t_dp_cmd;

endpackage

// ===== sv/jpic_regs.sv =====
// jpic_regs: apb-style configuration registers of the controller
// depends on jpic_pkg for the register map and the t_cfg struct
module jpic_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [jpic_pkg::APB_AW-1:0] paddr,
    input  logic [jpic_pkg::APB_DW-1:0] pwdata,
    output logic [jpic_pkg::APB_DW-1:0] prdata,
    output logic                       pready,
    output jpic_pkg::t_cfg             o_cfg
);

    jpic_pkg::t_cfg r_cfg;
    logic [2:0]     w_idx;
    logic           w_wr;

    assign pready = 1'b1;
    assign w_idx  = paddr[4:2];
    assign w_wr   = psel && penable && pwrite && pready;

    // register write, masked to field width
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode            <= jpic_pkg::MODE_OFF;
            r_cfg.gain_p          <= '0;
            r_cfg.gain_i_dt       <= '0;
            r_cfg.gain_d_over_dt  <= '0;
            r_cfg.filter_alpha    <= jpic_pkg::ALPHA_ONE;
            r_cfg.torque_limit    <= jpic_pkg::TORQUE_LIM_RST;
            r_cfg.gain_ff_gravity <= '0;
            r_cfg.gain_ff_damping <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                jpic_pkg::REG_MODE:            r_cfg.mode            <= pwdata[1:0];
                jpic_pkg::REG_GAIN_P:          r_cfg.gain_p          <= pwdata[15:0];
                jpic_pkg::REG_GAIN_I_DT:       r_cfg.gain_i_dt       <= pwdata[15:0];
                jpic_pkg::REG_GAIN_D_OVER_DT:  r_cfg.gain_d_over_dt  <= pwdata[15:0];
                jpic_pkg::REG_FILTER_ALPHA:    r_cfg.filter_alpha    <= pwdata[16:0];
                jpic_pkg::REG_TORQUE_LIMIT:    r_cfg.torque_limit    <= pwdata[14:0];
                jpic_pkg::REG_GAIN_FF_GRAVITY: r_cfg.gain_ff_gravity <= pwdata[15:0];
                jpic_pkg::REG_GAIN_FF_DAMPING: r_cfg.gain_ff_damping <= pwdata[15:0];
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (w_idx)
            jpic_pkg::REG_MODE:            prdata = 32'(r_cfg.mode);
            jpic_pkg::REG_GAIN_P:          prdata = 32'(r_cfg.gain_p);
            jpic_pkg::REG_GAIN_I_DT:       prdata = 32'(r_cfg.gain_i_dt);
            jpic_pkg::REG_GAIN_D_OVER_DT:  prdata = 32'(r_cfg.gain_d_over_dt);
            jpic_pkg::REG_FILTER_ALPHA:    prdata = 32'(r_cfg.filter_alpha);
            jpic_pkg::REG_TORQUE_LIMIT:    prdata = 32'(r_cfg.torque_limit);
            jpic_pkg::REG_GAIN_FF_GRAVITY: prdata = 32'(r_cfg.gain_ff_gravity);
            jpic_pkg::REG_GAIN_FF_DAMPING: prdata = 32'(r_cfg.gain_ff_damping);
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ===== sv/jpic_ctrl.sv =====
// jpic_ctrl: sequencer of the controller, steps the shared multiplier schedule
// depends on jpic_pkg for mode codes and the t_dp_cmd command struct
module jpic_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [1:0]        i_mode,
    input  logic              i_valid,
    output logic              o_ready,
    output logic              o_valid,
    input  logic              i_ready,
    output jpic_pkg::t_dp_cmd o_cmd
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_PF_A = 4'd1;
    localparam logic [3:0] ST_PF_B = 4'd2;
    localparam logic [3:0] ST_PF_C = 4'd3;
    localparam logic [3:0] ST_VF_A = 4'd4;
    localparam logic [3:0] ST_VF_B = 4'd5;
    localparam logic [3:0] ST_VF_C = 4'd6;
    localparam logic [3:0] ST_T0   = 4'd7;
    localparam logic [3:0] ST_T1   = 4'd8;
    localparam logic [3:0] ST_T2   = 4'd9;
    localparam logic [3:0] ST_T3   = 4'd10;
    localparam logic [3:0] ST_T4   = 4'd11;
    localparam logic [3:0] ST_FIN  = 4'd12;

    logic [3:0] r_state, n_state;
    logic [1:0] r_step, n_step;
    logic       r_out_valid, n_out_valid;
    logic       w_pid, w_imp, w_slot_free;

    assign w_pid       = (i_mode == jpic_pkg::MODE_PID);
    assign w_imp       = (i_mode == jpic_pkg::MODE_IMP);
    assign w_slot_free = !r_out_valid || i_ready;
    assign o_ready     = (r_state == ST_IDLE);
    assign o_valid     = r_out_valid;

    // next state and command decode
    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        o_cmd.opsel   = jpic_pkg::OP_POS_KEEP;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = (w_pid || w_imp) ? ST_PF_A : ST_FIN;
                end
            end
            ST_PF_A: begin
                o_cmd.opsel = jpic_pkg::OP_POS_KEEP;
                n_state = ST_PF_B;
            end
            ST_PF_B: begin
                o_cmd.opsel    = jpic_pkg::OP_POS_NEW;
                o_cmd.acc_load = 1'b1;
                n_state = ST_PF_C;
            end
            ST_PF_C: begin
                o_cmd.pos_wr = 1'b1;
                o_cmd.d_zero = (r_step == 2'd1);
                n_state = w_imp ? ST_VF_A : ST_T0;
            end
            ST_VF_A: begin
                o_cmd.opsel = jpic_pkg::OP_VEL_KEEP;
                n_state = ST_VF_B;
            end
            ST_VF_B: begin
                o_cmd.opsel    = jpic_pkg::OP_VEL_NEW;
                o_cmd.acc_load = 1'b1;
                n_state = ST_VF_C;
            end
            ST_VF_C: begin
                o_cmd.vel_wr = 1'b1;
                n_state = ST_T0;
            end
            ST_T0: begin
                o_cmd.opsel  = jpic_pkg::OP_P_ERR;
                o_cmd.sum_wr = w_pid;
                n_state = ST_T1;
            end
            ST_T1: begin
                o_cmd.opsel    = w_pid ? jpic_pkg::OP_I_SUM : jpic_pkg::OP_D_VEL;
                o_cmd.acc_load = 1'b1;
                o_cmd.shift3   = 1'b1;
                n_state = ST_T2;
            end
            ST_T2: begin
                o_cmd.opsel   = w_pid ? jpic_pkg::OP_D_DIFF : jpic_pkg::OP_FF_RATE;
                o_cmd.acc_add = 1'b1;
                o_cmd.shift3  = 1'b1;
                n_state = ST_T3;
            end
            ST_T3: begin
                o_cmd.opsel   = w_pid ? jpic_pkg::OP_FF_REF : jpic_pkg::OP_G_SINE;
                o_cmd.acc_add = 1'b1;
                o_cmd.shift3  = 1'b1;
                n_state = ST_T4;
            end
            ST_T4: begin
                // gravity term is already q.22, reference term is not
                o_cmd.acc_add = 1'b1;
                o_cmd.shift3  = w_pid;
                n_state = ST_FIN;
            end
            ST_FIN: begin
                if (w_slot_free) begin
                    o_cmd.out_wr   = 1'b1;
                    o_cmd.out_zero = !(w_pid || w_imp);
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // step count and output word flag
    always_comb begin
        n_step      = r_step;
        n_out_valid = r_out_valid;
        if (o_cmd.out_wr) begin
            n_out_valid = 1'b1;
            if (r_step != 2'd3) begin
                n_step = r_step + 2'd1;
            end
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    // a held output word is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> !($past(o_cmd.out_wr)))
        else $error("output word overwritten while stalled");

    // step count saturates at three
    a_step_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == 2'd3) |=> (r_step == 2'd3))
        else $error("step count left saturation");

    // an off-mode word goes straight to the finish step
    a_off_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && !w_pid && !w_imp) |=> (r_state == ST_FIN))
        else $error("off-mode word took the long path");

    // the error filter write is followed by the velocity filter or the term sequence
    a_after_pf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.pos_wr |=> (r_state == ST_VF_A || r_state == ST_T0))
        else $error("bad step after error filter");

endmodule

// ===== sv/jpic_dp.sv =====
// jpic_dp: datapath with the shared multiplier, accumulator, filter state and sine lookup
// depends on jpic_pkg for constants, t_cfg and t_dp_cmd
module jpic_dp #(
    parameter int SINE_TABLE_DEPTH = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  jpic_pkg::t_cfg      i_cfg,
    input  jpic_pkg::t_dp_cmd   i_cmd,
    input  logic signed [15:0]  i_angle,
    input  logic signed [15:0]  i_angle_ref,
    input  logic signed [15:0]  i_rate,
    input  logic signed [15:0]  i_rate_ref,
    output logic signed [15:0]  o_torque,
    output logic signed [15:0]  o_filtered_error,
    output logic                o_clamped
);

    localparam int IdxW = $clog2(SINE_TABLE_DEPTH);
    localparam int QW   = IdxW + 1;
    localparam int XW   = 14 + IdxW + 1;
    localparam int RW   = XW + 19;
    localparam logic [18:0] Recip =
        19'((64'd1 << 32) / 64'(jpic_pkg::TWO_PI_Q11));
    localparam logic [16:0] TwoPi  = 17'(jpic_pkg::TWO_PI_Q11);
    localparam logic [16:0] TwoPi2 = 17'(2 * jpic_pkg::TWO_PI_Q11);
    localparam logic [16:0] TwoPi4 = 17'(4 * jpic_pkg::TWO_PI_Q11);
    localparam logic [16:0] WrapOfs = 17'(3 * jpic_pkg::TWO_PI_Q11);

    // sine entry in q1.14, folded to a quarter turn, ninth order series in q28
    function automatic logic signed [15:0] sine_entry(input int unsigned k);
        longint unsigned f;
        longint unsigned mag;
        longint unsigned m2;
        longint unsigned t;
        longint unsigned s;
        logic            neg;
        f   = (64'(k) << 30) / 64'(SINE_TABLE_DEPTH);
        neg = 1'b0;
        if (f >= (64'd3 << 28)) begin
            mag = (64'd1 << 30) - f;
            neg = 1'b1;
        end else if (f > (64'd1 << 28)) begin
            if (f <= (64'd1 << 29)) begin
                mag = (64'd1 << 29) - f;
            end else begin
                mag = f - (64'd1 << 29);
            end
            neg = (f > (64'd1 << 29));
        end else begin
            mag = f;
        end
        mag = (mag * jpic_pkg::HALF_PI_Q28) >> 28;
        m2  = (mag * mag) >> 28;
        t   = jpic_pkg::ONE_Q28 - m2 / 64'd72;
        t   = jpic_pkg::ONE_Q28 - ((m2 * t) >> 28) / 64'd42;
        t   = jpic_pkg::ONE_Q28 - ((m2 * t) >> 28) / 64'd20;
        t   = jpic_pkg::ONE_Q28 - ((m2 * t) >> 28) / 64'd6;
        s   = (mag * t) >> 28;
        s   = (s + 64'd8192) >> 14;
        return neg ? -16'(s) : 16'(s);
    endfunction

    // captured word
    logic signed [15:0] r_angle, r_angle_ref, r_rate, r_rate_ref;

    // controller state
    logic signed [15:0] r_pos_err, r_vel_err;
    logic signed [31:0] r_err_sum;
    logic signed [16:0] r_d;

    // multiplier and accumulator
    logic signed [jpic_pkg::MUL_AW-1:0] w_mul_a;
    logic signed [jpic_pkg::MUL_BW-1:0] w_mul_b;
    logic signed [jpic_pkg::MUL_PW-1:0] w_mul_p, r_prod;
    logic signed [jpic_pkg::ACC_W-1:0]  r_acc, w_prodv;

    // output word
    logic signed [15:0] r_torque, r_out_err;
    logic               r_clamped;

    // sine lookup pipeline
    logic signed [15:0] w_sine_rom [SINE_TABLE_DEPTH];
    logic [16:0]        w_ofs, w_red1, w_red2, w_red3;
    logic [13:0]        r_ang_red;
    logic [XW-1:0]      r_x, r_x2, w_rem;
    logic [RW-1:0]      w_qp;
    logic [QW-1:0]      r_q;
    logic [IdxW-1:0]    r_idx;
    logic signed [15:0] r_sine;

    // filter weights, alpha above one acts as one
    logic [16:0] w_alpha, w_keep;
    logic signed [16:0] w_pdiff, w_vdiff;

    assign w_alpha = (i_cfg.filter_alpha > jpic_pkg::ALPHA_ONE) ? jpic_pkg::ALPHA_ONE
                                                                : i_cfg.filter_alpha;
    assign w_keep  = jpic_pkg::ALPHA_ONE - w_alpha;
    assign w_pdiff = 17'(r_angle_ref) - 17'(r_angle);
    assign w_vdiff = 17'(r_rate_ref) - 17'(r_rate);

    // operand select for the shared multiplier
    always_comb begin
        unique case (i_cmd.opsel)
            jpic_pkg::OP_POS_KEEP: begin
                w_mul_a = 33'(r_pos_err);
                w_mul_b = 18'($signed({1'b0, w_keep}));
            end
            jpic_pkg::OP_POS_NEW: begin
                w_mul_a = 33'(w_pdiff);
                w_mul_b = 18'($signed({1'b0, w_alpha}));
            end
            jpic_pkg::OP_VEL_KEEP: begin
                w_mul_a = 33'(r_vel_err);
                w_mul_b = 18'($signed({1'b0, w_keep}));
            end
            jpic_pkg::OP_VEL_NEW: begin
                w_mul_a = 33'(w_vdiff);
                w_mul_b = 18'($signed({1'b0, w_alpha}));
            end
            jpic_pkg::OP_P_ERR: begin
                w_mul_a = 33'(r_pos_err);
                w_mul_b = 18'($signed({1'b0, i_cfg.gain_p}));
            end
            jpic_pkg::OP_I_SUM: begin
                w_mul_a = 33'(r_err_sum);
                w_mul_b = 18'($signed({1'b0, i_cfg.gain_i_dt}));
            end
            jpic_pkg::OP_D_DIFF: begin
                w_mul_a = 33'(r_d);
                w_mul_b = 18'($signed({1'b0, i_cfg.gain_d_over_dt}));
            end
            jpic_pkg::OP_D_VEL: begin
                w_mul_a = 33'(r_vel_err);
                w_mul_b = 18'($signed({1'b0, i_cfg.gain_d_over_dt}));
            end
            jpic_pkg::OP_FF_REF: begin
                w_mul_a = 33'(r_angle_ref);
                w_mul_b = 18'($signed({1'b0, i_cfg.gain_ff_gravity}));
            end
            jpic_pkg::OP_FF_RATE: begin
                w_mul_a = 33'(r_rate);
                w_mul_b = 18'($signed({1'b0, i_cfg.gain_ff_damping}));
            end
            jpic_pkg::OP_G_SINE: begin
                w_mul_a = 33'(r_sine);
                w_mul_b = 18'($signed({1'b0, i_cfg.gain_ff_gravity}));
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_mul_p = w_mul_a * w_mul_b;
    assign w_prodv = i_cmd.shift3 ? (jpic_pkg::ACC_W'(r_prod) <<< 3)
                                  : jpic_pkg::ACC_W'(r_prod);

    // filter result: round to q4.11 and saturate
    logic signed [jpic_pkg::ACC_W-1:0] w_fsum, w_fsh;
    logic signed [15:0]                w_filt;
    logic signed [16:0]                w_dnew;

    assign w_fsum = r_acc + w_prodv;
    assign w_fsh  = (w_fsum + jpic_pkg::ACC_W'(32768)) >>> 16;

    always_comb begin
        if (w_fsh > jpic_pkg::ACC_W'(32767)) begin
            w_filt = 16'sh7FFF;
        end else if (w_fsh < -jpic_pkg::ACC_W'(32768)) begin
            w_filt = -16'sh8000;
        end else begin
            w_filt = 16'(w_fsh);
        end
    end

    assign w_dnew = i_cmd.d_zero ? 17'sd0 : (17'(w_filt) - 17'(r_pos_err));

    // saturating error sum
    logic signed [32:0] w_sum33;
    logic signed [31:0] w_sum_sat;

    assign w_sum33 = 33'(r_err_sum) + 33'(r_pos_err);
    always_comb begin
        if (w_sum33[32] != w_sum33[31]) begin
            w_sum_sat = w_sum33[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            w_sum_sat = w_sum33[31:0];
        end
    end

    // torque rounding to q7.8 and clamp
    logic signed [jpic_pkg::ACC_W-1:0] w_raw, w_lim;
    logic signed [15:0]                w_tq;
    logic                              w_tq_clamped;

    assign w_raw = (r_acc + jpic_pkg::ACC_W'(8192)) >>> 14;
    assign w_lim = jpic_pkg::ACC_W'($signed({1'b0, i_cfg.torque_limit}));

    always_comb begin
        if (w_raw > w_lim) begin
            w_tq         = 16'(w_lim);
            w_tq_clamped = 1'b1;
        end else if (w_raw < -w_lim) begin
            w_tq         = 16'(-w_lim);
            w_tq_clamped = 1'b1;
        end else begin
            w_tq         = 16'(w_raw);
            w_tq_clamped = 1'b0;
        end
    end

    // filter and integrator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_err <= '0;
            r_vel_err <= '0;
            r_err_sum <= '0;
        end else begin
            if (i_cmd.pos_wr) begin
                r_pos_err <= w_filt;
            end
            if (i_cmd.vel_wr) begin
                r_vel_err <= w_filt;
            end
            if (i_cmd.sum_wr) begin
                r_err_sum <= w_sum_sat;
            end
        end
    end

    // word capture, product, accumulator and output word
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_angle     <= i_angle;
            r_angle_ref <= i_angle_ref;
            r_rate      <= i_rate;
            r_rate_ref  <= i_rate_ref;
        end
        if (i_cmd.pos_wr) begin
            r_d <= w_dnew;
        end
        r_prod <= w_mul_p;
        if (i_cmd.acc_load) begin
            r_acc <= w_prodv;
        end else if (i_cmd.acc_add) begin
            r_acc <= w_fsum;
        end
        if (i_cmd.out_wr) begin
            r_torque  <= i_cmd.out_zero ? 16'sd0 : w_tq;
            r_clamped <= i_cmd.out_zero ? 1'b0 : w_tq_clamped;
            r_out_err <= r_pos_err;
        end
    end

    // sine table, one constant entry per index
    for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_rom
        assign w_sine_rom[k] = sine_entry(32'(k));
    end

    // angle reduced modulo two pi into [0, two pi)
    assign w_ofs  = 17'({r_angle[15], r_angle}) + WrapOfs;
    assign w_red1 = (w_ofs  >= TwoPi4) ? (w_ofs  - TwoPi4) : w_ofs;
    assign w_red2 = (w_red1 >= TwoPi2) ? (w_red1 - TwoPi2) : w_red1;
    assign w_red3 = (w_red2 >= TwoPi)  ? (w_red2 - TwoPi)  : w_red2;

    // index = floor(reduced * depth / two pi) by reciprocal and one correction
    assign w_qp  = RW'(r_x) * RW'(Recip);
    assign w_rem = r_x2 - XW'(XW'(r_q) * XW'(jpic_pkg::TWO_PI_Q11));

    always_ff @(posedge i_clk) begin
        r_ang_red <= w_red3[13:0];
        r_x       <= XW'(r_ang_red) * XW'(SINE_TABLE_DEPTH);
        r_x2      <= r_x;
        r_q       <= QW'(w_qp >> 32);
        r_idx     <= (w_rem >= XW'(jpic_pkg::TWO_PI_Q11)) ? IdxW'(r_q + QW'(1))
                                                          : IdxW'(r_q);
        r_sine    <= w_sine_rom[r_idx];
    end

    assign o_torque         = r_torque;
    assign o_filtered_error = r_out_err;
    assign o_clamped        = r_clamped;

endmodule

// ===== sv/joint_pid_impedance_controller.sv =====
// Joint PID / impedance controller: one torque command per control tick, with a
// low-pass error filter, saturating integrator and sine-table gravity feedforward.
// A PID word runs the error filter and then the torque terms; an impedance word runs the
// error filter, the velocity filter and then the torque terms; an off-mode word goes
// straight to the finish step. These steps run one after another on the single shared
// 33x18 multiplier that evaluates the filter products and every torque term. The block
// works on one word at a time and takes the next word as soon as the result is in the
// output register, even if that result is still waiting. Gains, filter weight and limit
// are to be written through the APB port only while no word is in flight; the block does
// not enforce this. SINE_TABLE_DEPTH (64 to 4096) sets the gravity sine table size.
// depends on jpic_pkg, jpic_regs, jpic_ctrl, jpic_dp
module joint_pid_impedance_controller #(
    parameter int SINE_TABLE_DEPTH = 256
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [jpic_pkg::APB_AW-1:0] paddr,
    input  logic [jpic_pkg::APB_DW-1:0] pwdata,
    output logic [jpic_pkg::APB_DW-1:0] prdata,
    output logic                        pready,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic signed [15:0]          i_angle,
    input  logic signed [15:0]          i_angle_ref,
    input  logic signed [15:0]          i_rate,
    input  logic signed [15:0]          i_rate_ref,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic signed [15:0]          o_torque,
    output logic signed [15:0]          o_filtered_error,
    output logic                        o_clamped
);

    jpic_pkg::t_cfg    w_cfg;
    jpic_pkg::t_dp_cmd w_cmd;

    // configuration registers
    jpic_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // sequencer
    jpic_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mode  (w_cfg.mode),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_cmd   (w_cmd)
    );

    // arithmetic
    jpic_dp #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (w_cfg),
        .i_cmd            (w_cmd),
        .i_angle          (i_angle),
        .i_angle_ref      (i_angle_ref),
        .i_rate           (i_rate),
        .i_rate_ref       (i_rate_ref),
        .o_torque         (o_torque),
        .o_filtered_error (o_filtered_error),
        .o_clamped        (o_clamped)
    );

endmodule
